// ===== rtl/core/cdq_pkg.sv =====
`default_nettype none

package cdq_pkg;

	localparam int CFG_W     = 5;
	localparam int DATA_W    = 32;
	localparam int CAP_RESET = 16;

	typedef enum logic [2:0] {
		OP_INS_FRONT = 3'd0,
		OP_INS_REAR  = 3'd1,
		OP_DEL_FRONT = 3'd2,
		OP_DEL_REAR  = 3'd3,
		OP_QUERY     = 3'd4
	} op_t;

	typedef struct packed {
		logic [2:0]               opcode;
		logic signed [DATA_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic                     ok;
		logic signed [DATA_W-1:0] front_value;
		logic signed [DATA_W-1:0] rear_value;
		logic                     values_valid;
		logic                     is_empty;
		logic                     is_full;
	} res_t;

	// controller -> datapath commands
	typedef struct packed {
		logic load;    // capture request word
		logic exec;    // update indices, count, store write
		logic read;    // read front/rear entries, latch flags
		logic cfg_wr;  // capacity write, empties the deque
	} ctl_t;

endpackage

`default_nettype wire

// ===== rtl/core/cdq_ctrl.sv =====
`default_nettype none

module cdq_ctrl
	import cdq_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire logic cfg_valid,
	output logic      busy,
	output logic      cfg_ready,
	output logic      done,
	output ctl_t      ctl
);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_EXEC = 4'b0010,
		S_READ = 4'b0100,
		S_OUT  = 4'b1000
	} state_t;

	state_t state_q, state_nxt;
	logic   accept;

	assign busy      = (state_q == S_EXEC) || (state_q == S_READ);
	assign accept    = start && !busy;
	assign cfg_ready = (state_q == S_IDLE);
	assign done      = (state_q == S_OUT);

	always_comb begin
		ctl.load   = accept;
		ctl.exec   = (state_q == S_EXEC);
		ctl.read   = (state_q == S_READ);
		ctl.cfg_wr = cfg_valid && cfg_ready;
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) state_nxt = S_EXEC;
			end
			S_EXEC: state_nxt = S_READ;
			S_READ: state_nxt = S_OUT;
			S_OUT: begin
				state_nxt = accept ? S_EXEC : S_IDLE;
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/cdq_dpath.sv =====
`default_nettype none

module cdq_dpath
	import cdq_pkg::*;
#(
	parameter int MAX_DEPTH = 16
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire ctl_t             ctl,
	input  wire req_t             cmd,
	input  wire logic [CFG_W-1:0] cfg_data,
	output res_t                  result
);

	localparam int IDX_W   = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
	localparam int CNT_W   = $clog2(MAX_DEPTH + 1) > 0 ? $clog2(MAX_DEPTH + 1) : 1;
	localparam int CAP_RST = (MAX_DEPTH < CAP_RESET) ? MAX_DEPTH : CAP_RESET;

	logic [DATA_W-1:0] mem [MAX_DEPTH];

	logic [2:0]        op_q;
	logic [DATA_W-1:0] val_q;
	logic [CNT_W-1:0]  cap_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [IDX_W-1:0]  front_q;
	logic [IDX_W-1:0]  rear_q;

	logic              ok_q;
	logic              valid_q;
	logic              full_q;
	logic [DATA_W-1:0] front_rd_q;
	logic [DATA_W-1:0] rear_rd_q;

	logic [CNT_W-1:0]  cap_new;
	logic [IDX_W-1:0]  cap_m1;
	logic [IDX_W-1:0]  front_inc, front_dec, rear_inc, rear_dec;
	logic              has_room, has_item;

	logic              wr_en;
	logic [IDX_W-1:0]  wr_addr;
	logic [IDX_W-1:0]  front_nxt, rear_nxt;
	logic [CNT_W-1:0]  cnt_nxt;
	logic              ok_nxt;

	// ring step modulo current capacity
	function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] idx,
	                                             input logic [CNT_W-1:0] cap);
		logic [CNT_W-1:0] nxt;
		nxt = CNT_W'(idx) + CNT_W'(1);
		return (nxt == cap) ? '0 : IDX_W'(nxt);
	endfunction

	function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] idx,
	                                             input logic [IDX_W-1:0] top);
		return (idx == '0) ? top : idx - IDX_W'(1);
	endfunction

	// capacity clamp: zero -> one, above depth -> depth
	always_comb begin
		if (cfg_data == '0) begin
			cap_new = CNT_W'(1);
		end else if (32'(cfg_data) > 32'(MAX_DEPTH)) begin
			cap_new = CNT_W'(MAX_DEPTH);
		end else begin
			cap_new = CNT_W'(cfg_data);
		end
	end

	assign cap_m1    = IDX_W'(cap_q - CNT_W'(1));
	assign front_inc = idx_inc(front_q, cap_q);
	assign rear_inc  = idx_inc(rear_q, cap_q);
	assign front_dec = idx_dec(front_q, cap_m1);
	assign rear_dec  = idx_dec(rear_q, cap_m1);
	assign has_room  = cnt_q < cap_q;
	assign has_item  = cnt_q != '0;

	always_comb begin
		wr_en     = 1'b0;
		wr_addr   = front_inc;
		front_nxt = front_q;
		rear_nxt  = rear_q;
		cnt_nxt   = cnt_q;
		ok_nxt    = 1'b0;
		case (op_q)
			OP_INS_FRONT: begin
				if (has_room) begin
					front_nxt = front_inc;
					wr_en     = 1'b1;
					wr_addr   = front_inc;
					cnt_nxt   = cnt_q + CNT_W'(1);
					ok_nxt    = 1'b1;
				end
			end
			OP_INS_REAR: begin
				if (has_room) begin
					rear_nxt = rear_dec;
					wr_en    = 1'b1;
					wr_addr  = rear_dec;
					cnt_nxt  = cnt_q + CNT_W'(1);
					ok_nxt   = 1'b1;
				end
			end
			OP_DEL_FRONT: begin
				if (has_item) begin
					front_nxt = front_dec;
					cnt_nxt   = cnt_q - CNT_W'(1);
					ok_nxt    = 1'b1;
				end
			end
			OP_DEL_REAR: begin
				if (has_item) begin
					rear_nxt = rear_inc;
					cnt_nxt  = cnt_q - CNT_W'(1);
					ok_nxt   = 1'b1;
				end
			end
			OP_QUERY: ok_nxt = 1'b1;
			default:  ok_nxt = 1'b0;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q   <= CNT_W'(CAP_RST);
			front_q <= IDX_W'(CAP_RST - 1);
			rear_q  <= '0;
			cnt_q   <= '0;
		end else if (ctl.cfg_wr) begin
			cap_q   <= cap_new;
			front_q <= IDX_W'(cap_new - CNT_W'(1));
			rear_q  <= '0;
			cnt_q   <= '0;
		end else if (ctl.exec) begin
			front_q <= front_nxt;
			rear_q  <= rear_nxt;
			cnt_q   <= cnt_nxt;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			op_q  <= cmd.opcode;
			val_q <= cmd.value;
		end
		if (ctl.exec) begin
			ok_q <= ok_nxt;
		end
		if (ctl.read) begin
			valid_q <= has_item;
			full_q  <= (cnt_q == cap_q);
		end
	end

	// ring store
	always_ff @(posedge clk) begin
		if (ctl.exec && wr_en) begin
			mem[wr_addr] <= val_q;
		end
		if (ctl.read) begin
			front_rd_q <= mem[front_q];
			rear_rd_q  <= mem[rear_q];
		end
	end

	always_comb begin
		result.ok           = ok_q;
		result.front_value  = valid_q ? front_rd_q : '0;
		result.rear_value   = valid_q ? rear_rd_q : '0;
		result.values_valid = valid_q;
		result.is_empty     = !valid_q;
		result.is_full      = full_q;
	end

endmodule

`default_nettype wire

// ===== rtl/core/circular_deque.sv =====
`default_nettype none

// Double-ended queue over a ring store of MAX_DEPTH 32-bit entries, of which
// the capacity register selects how many are in use (0 reads as 1, values
// above MAX_DEPTH saturate; reset capacity is 16, or MAX_DEPTH if smaller).
// A word is taken on a clock edge with start high and busy low. The block
// then steps through its exec and read states, and the result shows on
// result for exactly one cycle, marked by done.
// The receiver cannot stall: capture result whenever done is high. A new
// word may be started in the cycle done is high, so items run back to back
// through the store access sequence: the index update and store write, the
// registered read of front and rear entries, and presenting the word.
// Capacity writes go through cfg_valid/cfg_ready; cfg_ready is high only
// while the block is idle, and a write empties the deque.
module circular_deque
	import cdq_pkg::*;
#(
	parameter int MAX_DEPTH = 16
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	output logic                  busy,
	input  wire req_t             cmd,
	output logic                  done,
	output res_t                  result,
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic [CFG_W-1:0] cfg_data
);

	ctl_t ctl;

	// sequencing: idle -> exec -> read -> out
	cdq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.cfg_valid (cfg_valid),
		.busy      (busy),
		.cfg_ready (cfg_ready),
		.done      (done),
		.ctl       (ctl)
	);

	// indices, count, capacity, ring store and result registers
	cdq_dpath #(
		.MAX_DEPTH (MAX_DEPTH)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.cmd      (cmd),
		.cfg_data (cfg_data),
		.result   (result)
	);

endmodule

`default_nettype wire

// ===== tb/sv/circular_deque_check.sv =====
`default_nettype none

module circular_deque_check
	import cdq_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic             busy,
	input  wire req_t             cmd,
	input  wire logic             done,
	input  wire res_t             result,
	input  wire logic             cfg_valid,
	input  wire logic             cfg_ready,
	input  wire logic [CFG_W-1:0] cfg_data,
	output int                    mismatches,
	output int                    outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH = 16;
	localparam int IDX_W = $clog2(DEPTH);

	// shadow deque
	logic [DATA_W-1:0] ring [DEPTH];
	int unsigned       head;
	int unsigned       tail;
	int unsigned       fill;
	int unsigned       cap;

	res_t views_due [$];
	int   err_total;

	// applies one word to the shadow deque, returns the view after it
	function automatic res_t step_deque(req_t w);
		res_t v;
		v = '0;
		case (w.opcode)
			OP_INS_FRONT: if (fill < cap) begin
				head = (head + 1) % cap;
				ring[head[IDX_W-1:0]] = w.value;
				fill++;
				v.ok = 1'b1;
			end
			OP_INS_REAR: if (fill < cap) begin
				tail = (tail + cap - 1) % cap;
				ring[tail[IDX_W-1:0]] = w.value;
				fill++;
				v.ok = 1'b1;
			end
			OP_DEL_FRONT: if (fill > 0) begin
				head = (head + cap - 1) % cap;
				fill--;
				v.ok = 1'b1;
			end
			OP_DEL_REAR: if (fill > 0) begin
				tail = (tail + 1) % cap;
				fill--;
				v.ok = 1'b1;
			end
			OP_QUERY: v.ok = 1'b1;
			default: v.ok = 1'b0;
		endcase
		v.values_valid = (fill != 0);
		v.is_empty     = (fill == 0);
		v.is_full      = (fill == cap);
		if (fill != 0) begin
			v.front_value = ring[head[IDX_W-1:0]];
			v.rear_value  = ring[tail[IDX_W-1:0]];
		end
		return v;
	endfunction

	task automatic compare_field(string field, logic [DATA_W-1:0] want,
			logic [DATA_W-1:0] got);
		if (got !== want) begin
			err_total++;
			$display("%0t deque %s: expected %h, got %h", $time, field, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			views_due.delete();
			foreach (ring[i]) ring[i] = '0;
			cap  = CAP_RESET;
			head = cap - 1;
			tail = 0;
			fill = 0;
			err_total = 0;
			mismatches  <= 0;
			outstanding <= 0;
		end else begin
			// result first: a word taken on this edge queues behind it
			if (done) begin
				if (views_due.size() == 0) begin
					err_total++;
					$display("%0t deque: unexpected result word, got %h", $time, result);
				end else begin
					want = views_due.pop_front();
					compare_field("ok", DATA_W'(want.ok), DATA_W'(result.ok));
					compare_field("front_value", want.front_value, result.front_value);
					compare_field("rear_value", want.rear_value, result.rear_value);
					compare_field("values_valid", DATA_W'(want.values_valid),
						DATA_W'(result.values_valid));
					compare_field("is_empty", DATA_W'(want.is_empty),
						DATA_W'(result.is_empty));
					compare_field("is_full", DATA_W'(want.is_full),
						DATA_W'(result.is_full));
				end
			end
			if (cfg_valid && cfg_ready) begin
				// 0 acts as 1, anything above the ring size saturates
				cap  = (cfg_data == 0) ? 1 : (cfg_data > DEPTH) ? DEPTH : cfg_data;
				head = cap - 1;
				tail = 0;
				fill = 0;
			end
			if (start && !busy)
				views_due.push_back(step_deque(cmd));
			mismatches  <= err_total;
			outstanding <= views_due.size();
		end
	end

endmodule

`default_nettype wire

// ===== tb/sv/circular_deque_test.sv =====
`default_nettype none

module circular_deque_test;
	timeunit 1ns;
	timeprecision 1ps;

	import cdq_pkg::*;

	// cycles with no word moving on any channel before we give up
	localparam int WATCH_LIMIT   = 2000;
	// quiet cycles after the last result, to catch stray strobes
	localparam int SETTLE_CYCLES = 8;
	localparam int ITEM_GOAL     = 1700;
	// last stretch of the run goes back to back, with no random gaps
	localparam int QUIET_TAIL    = 250;

	// opcodes 5..7 are undefined; the block must answer them with ok low
	localparam logic [2:0] OP_SPARE_LO = OP_QUERY + 3'd1;
	localparam logic [2:0] OP_SPARE_HI = '1;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             start     = 1'b0;
	req_t             cmd       = '0;
	logic             cfg_valid = 1'b0;
	logic [CFG_W-1:0] cfg_data  = '0;
	logic             busy;
	logic             done;
	res_t             result;
	logic             cfg_ready;

	int mismatches;
	int outstanding;
	int words_sent = 0;
	int stall_cycles = 0;
	bit gaps_on = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	circular_deque dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.done      (done),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	circular_deque_check check (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.cmd         (cmd),
		.done        (done),
		.result      (result),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	// Watchdog: any word on the command, result or config channel resets it.
	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= WATCH_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Hold start high until the block takes the word. start stays high on
	// the accepting edge so back-to-back words need no extra toggling; an
	// idle burst drops it right after acceptance so gaps land on every
	// state of the exec, read and out item sequence.
	task automatic push_word(logic [2:0] op, logic [DATA_W-1:0] val);
		start <= 1'b1;
		cmd   <= '{opcode: op, value: val};
		do @(posedge clk); while (busy);
		words_sent++;
		if (gaps_on && $urandom_range(0, 5) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
	endtask

	// Stop issuing and wait for every predicted result to come back.
	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	// Capacity writes only happen with the deque idle; cfg_ready gates them.
	task automatic write_capacity(logic [CFG_W-1:0] d);
		cfg_valid <= 1'b1;
		cfg_data  <= d;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// Mostly random data, with the signed extremes and all-ones/zero mixed in.
	function automatic logic [DATA_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2: return '0;
			3: return '1;
			default: return $urandom;
		endcase
	endfunction

	// insert_pct steers the fill level: high drives toward full, low toward
	// empty, so both boundaries see plenty of traffic.
	function automatic logic [2:0] pick_op(int insert_pct);
		int r;
		r = $urandom_range(0, 99);
		if (r < 4)
			return 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
		if (r < 10)
			return OP_QUERY;
		if ($urandom_range(0, 99) < insert_pct)
			return $urandom_range(0, 1) ? OP_INS_FRONT : OP_INS_REAR;
		return $urandom_range(0, 1) ? OP_DEL_FRONT : OP_DEL_REAR;
	endfunction

	initial begin
		int          insert_pct;
		int          n_words;
		logic [CFG_W-1:0] cap_pick;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed: reset capacity of 16 ---
		// empty deque: query shows no valid values, deletes fail
		push_word(OP_QUERY, '0);
		push_word(OP_DEL_FRONT, 32'h1234_5678);
		push_word(OP_DEL_REAR, '1);
		// extremes through both ends
		push_word(OP_INS_FRONT, 32'h7fff_ffff);
		push_word(OP_INS_REAR, 32'h8000_0000);
		push_word(OP_INS_FRONT, '1);
		push_word(OP_INS_REAR, '0);
		push_word(OP_QUERY, 32'h5555_5555);
		// undefined opcodes leave the deque alone
		for (int op = int'(OP_SPARE_LO); op <= int'(OP_SPARE_HI); op++)
			push_word(3'(op), 32'haaaa_aaaa);
		// unwind from both ends, last delete hits empty
		push_word(OP_DEL_FRONT, '0);
		push_word(OP_DEL_REAR, '0);
		push_word(OP_DEL_FRONT, '0);
		push_word(OP_DEL_REAR, '0);
		push_word(OP_DEL_REAR, '0);
		drain();

		// --- capacity one: a single insert makes it full ---
		write_capacity(CFG_W'(1));
		push_word(OP_INS_REAR, 32'h0000_0001);
		push_word(OP_INS_FRONT, 32'hdead_beef);
		push_word(OP_QUERY, '0);
		push_word(OP_DEL_FRONT, '0);
		push_word(OP_DEL_REAR, '0);
		drain();

		// --- capacity zero behaves as one ---
		write_capacity('0);
		push_word(OP_INS_FRONT, 32'h8000_0001);
		push_word(OP_INS_REAR, 32'h7fff_fffe);
		push_word(OP_DEL_REAR, '0);
		drain();

		// --- random phases, each with its own capacity and fill bias ---
		while (words_sent < ITEM_GOAL) begin
			case ($urandom_range(0, 7))
				0: cap_pick = '0;
				1: cap_pick = CFG_W'(1);
				2: cap_pick = CFG_W'(2);
				3: cap_pick = CFG_W'(CAP_RESET);
				4: cap_pick = CFG_W'($urandom_range(CAP_RESET + 1, (1 << CFG_W) - 1));
				5: cap_pick = '1;
				default: cap_pick = CFG_W'($urandom_range(1, CAP_RESET));
			endcase
			write_capacity(cap_pick);

			case ($urandom_range(0, 3))
				0: insert_pct = 25;
				1: insert_pct = 50;
				2: insert_pct = 75;
				default: insert_pct = 90;
			endcase
			// some phases run flat out, all do near the end
			gaps_on = (words_sent < ITEM_GOAL - QUIET_TAIL) && ($urandom_range(0, 3) != 0);
			n_words = $urandom_range(20, 80);

			repeat (n_words) begin
				push_word(pick_op(insert_pct), pick_value());
				// occasionally let the pipeline run dry mid-phase
				if ($urandom_range(0, 40) == 0)
					drain();
			end
			drain();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/core/cdq_pkg.sv
rtl/core/cdq_ctrl.sv
rtl/core/cdq_dpath.sv
rtl/core/circular_deque.sv
tb/sv/circular_deque_check.sv
tb/sv/circular_deque_test.sv
